// ===== sv/ofst_pkg.sv =====
// ofst_pkg: shared types and codes for the offer settle tracker
// entry layout in the row memory, status codes and the row control structs
// no dependencies
package ofst_pkg;

   localparam int SEQ_W    = 32;
   localparam int CNT_W    = 16;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;

   // one entry in a row word: {used, seq, remaining}
   localparam int ENTRY_W  = 1 + SEQ_W + CNT_W;

   localparam logic KIND_ADD     = 1'b0;
   localparam logic KIND_DISPOSE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

   typedef struct packed {
      logic load;
      logic add;
      logic dispose;
      logic settle;
   } row_ctl_type;

   typedef struct packed {
      logic full;
      logic miss;
      logic advance;
   } row_flags_type;

endpackage

// ===== sv/ofst_ram.sv =====
// ofst_ram: generic single-port-write, single-port-read ram
// read data is registered; no dependencies
module ofst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ofst_row.sv =====
// ofst_row: working copy of one slot row and the add, dispose and settle steps
// loads a row word from the row memory and hands back the updated word
// depends on ofst_pkg
module ofst_row
   import ofst_pkg::*;
#(
   parameter int WINDOW_DEPTH = 8,
   localparam int ROW_W = WINDOW_DEPTH * ENTRY_W + SEQ_W
) (
   input  logic              clock,
   input  row_ctl_type       ctl,
   input  logic              row_valid,
   input  logic [ROW_W-1:0]  rd_row,
   input  logic [SEQ_W-1:0]  offer_seq,
   input  logic [CNT_W-1:0]  packet_count,
   output row_flags_type     flags,
   output logic [SEQ_W-1:0]  settled,
   output logic              moved,
   output logic [ROW_W-1:0]  wr_row
);

   localparam int WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   logic             used_ff [WINDOW_DEPTH];
   logic             used_in [WINDOW_DEPTH];
   logic [SEQ_W-1:0] seq_ff  [WINDOW_DEPTH];
   logic [SEQ_W-1:0] seq_in  [WINDOW_DEPTH];
   logic [CNT_W-1:0] rem_ff  [WINDOW_DEPTH];
   logic [CNT_W-1:0] rem_in  [WINDOW_DEPTH];
   logic [SEQ_W-1:0] settled_ff, settled_in;
   logic [SEQ_W-1:0] before_ff, before_in;

   logic [SEQ_W-1:0]  key;
   logic              hit_found, free_found;
   logic [WIN_AW-1:0] hit_idx, free_idx;

   // settle looks for settled + 1, dispose for the offered sequence
   assign key = ctl.settle ? (settled_ff + SEQ_W'(1)) : offer_seq;

   always_comb begin
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      // walk downward so the lowest index wins
      for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
         if (used_ff[i] && seq_ff[i] == key) begin
            hit_found = 1'b1;
            hit_idx   = WIN_AW'(i);
         end
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = WIN_AW'(i);
         end
      end
   end

   assign flags.full    = !free_found;
   assign flags.miss    = !hit_found;
   assign flags.advance = hit_found && (rem_ff[hit_idx] == '0);

   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         used_in[i] = used_ff[i];
         seq_in[i]  = seq_ff[i];
         rem_in[i]  = rem_ff[i];
      end
      settled_in = settled_ff;
      before_in  = before_ff;

      if (ctl.load) begin
         // a row never written reads as all free with settled at zero
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            used_in[i] = row_valid & rd_row[i*ENTRY_W + ENTRY_W - 1];
            seq_in[i]  = rd_row[i*ENTRY_W + CNT_W +: SEQ_W];
            rem_in[i]  = rd_row[i*ENTRY_W +: CNT_W];
         end
         settled_in = row_valid ? rd_row[WINDOW_DEPTH*ENTRY_W +: SEQ_W] : '0;
         before_in  = settled_in;
      end else if (ctl.add) begin
         if (free_found) begin
            used_in[free_idx] = 1'b1;
            seq_in[free_idx]  = offer_seq;
            rem_in[free_idx]  = packet_count;
         end
      end else if (ctl.dispose) begin
         if (hit_found && rem_ff[hit_idx] != '0) begin
            rem_in[hit_idx] = rem_ff[hit_idx] - CNT_W'(1);
         end
      end else if (ctl.settle) begin
         if (flags.advance) begin
            used_in[hit_idx] = 1'b0;
            settled_in       = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         used_ff[i] <= used_in[i];
         seq_ff[i]  <= seq_in[i];
         rem_ff[i]  <= rem_in[i];
      end
      settled_ff <= settled_in;
      before_ff  <= before_in;
   end

   always_comb begin
      wr_row = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         wr_row[i*ENTRY_W +: ENTRY_W] = {used_ff[i], seq_ff[i], rem_ff[i]};
      end
      wr_row[WINDOW_DEPTH*ENTRY_W +: SEQ_W] = settled_ff;
   end

   assign settled = settled_ff;
   assign moved   = (settled_ff != before_ff);

endmodule

// ===== sv/in_order_offer_settle_tracker.sv =====
// in_order_offer_settle_tracker: per-slot offer windows with in-order settling
// top level: control sequencer, row memory, row valid bits and result register
// depends on ofst_pkg, ofst_ram, ofst_row
//
//   channel  direction  fields
//   req      in         kind, slot, offer_seq, packet_count
//   rsp      out        status, settled_value, settled_moved
//
// one word at a time: read row, load, apply add or dispose, settle, write back
// add: read, load, apply the add, finish; dispose: read, load, apply, then settle passes
// that free one entry each (at most WINDOW_DEPTH in all), then finish; slot out of range: finish only
// reset clears the per-slot row valid bits; a row not yet written reads as empty
// a stalled rsp holds its word; the next req is taken while it waits
module in_order_offer_settle_tracker
   import ofst_pkg::*;
#(
   parameter int SLOT_COUNT   = 64,
   parameter int WINDOW_DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [SEQ_W-1:0]    req_offer_seq,
   input  logic [CNT_W-1:0]    req_packet_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SEQ_W-1:0]    rsp_settled_value,
   output logic                rsp_settled_moved
);

   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_XW = (SLOT_AW > SLOT_W) ? SLOT_AW : SLOT_W;
   localparam int ROW_W   = WINDOW_DEPTH * ENTRY_W + SEQ_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_OP     = 3'd3;
   localparam logic [2:0] ST_SETTLE = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic                  kind_ff, kind_in;
   logic [SLOT_AW-1:0]    slot_ff, slot_in;
   logic                  in_range_ff, in_range_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_COUNT-1:0] row_valid_ff, row_valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SEQ_W-1:0]      rsp_settled_ff, rsp_settled_in;
   logic                  rsp_moved_ff, rsp_moved_in;

   logic [SLOT_XW-1:0]    req_slot_x;
   logic                  accept, finish_fire;
   logic [ROW_W-1:0]      rd_row, wr_row;
   row_ctl_type           ctl;
   row_flags_type         flags;
   logic [SEQ_W-1:0]      row_settled;
   logic                  row_moved;

   assign req_slot_x  = SLOT_XW'(req_slot);
   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign finish_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   ofst_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SLOT_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (finish_fire && in_range_ff),
      .wr_addr (slot_ff),
      .wr_data (wr_row),
      .rd_addr (slot_ff),
      .rd_data (rd_row)
   );

   ofst_row #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_row (
      .clock        (clock),
      .ctl          (ctl),
      .row_valid    (row_valid_ff[slot_ff]),
      .rd_row       (rd_row),
      .offer_seq    (seq_ff),
      .packet_count (count_ff),
      .flags        (flags),
      .settled      (row_settled),
      .moved        (row_moved),
      .wr_row       (wr_row)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      in_range_in    = in_range_ff;
      seq_in         = seq_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      row_valid_in   = row_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_settled_in = rsp_settled_ff;
      rsp_moved_in   = rsp_moved_ff;
      ctl            = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in     = req_kind;
               slot_in     = req_slot_x[SLOT_AW-1:0];
               seq_in      = req_offer_seq;
               count_in    = req_packet_count;
               in_range_in = (32'(req_slot) < SLOT_COUNT);
               if (in_range_in) begin
                  state_in = ST_READ;
               end else begin
                  status_in = (req_kind == KIND_DISPOSE) ? STATUS_UNKNOWN : STATUS_FULL;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            state_in = ST_OP;
         end
         ST_OP: begin
            if (kind_ff == KIND_ADD) begin
               ctl.add   = 1'b1;
               status_in = flags.full ? STATUS_FULL : STATUS_OK;
               state_in  = ST_FINISH;
            end else begin
               ctl.dispose = 1'b1;
               status_in   = flags.miss ? STATUS_UNKNOWN : STATUS_OK;
               state_in    = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // each pass frees at most one entry
            ctl.settle = 1'b1;
            if (!flags.advance) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_fire) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_settled_in = in_range_ff ? row_settled : '0;
               rsp_moved_in   = in_range_ff && row_moved;
               if (in_range_ff) begin
                  row_valid_in[slot_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      slot_ff        <= slot_in;
      in_range_ff    <= in_range_in;
      seq_ff         <= seq_in;
      count_ff       <= count_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_settled_ff <= rsp_settled_in;
      rsp_moved_ff   <= rsp_moved_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_settled_value = rsp_settled_ff;
   assign rsp_settled_moved = rsp_moved_ff;

   // a taken word keeps the sequencer busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("req taken twice in a row");

   // settling only follows a dispose, so a full add never moves
   a_full_no_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> !rsp_moved_ff)
      else $error("settled moved on an add");

   // a new response only comes out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   // the row memory is written back only for an in-range slot; an out-of-range one reports zero and no move
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (finish_fire && !in_range_ff) |=> !rsp_moved_ff && rsp_settled_ff == '0)
      else $error("out of range slot reported state");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for in_order_offer_settle_tracker, add and dispose words in,
// settle response words checked against a local per-slot window predictor
// depends on ofst_pkg and the in_order_offer_settle_tracker RTL
module tb;
   import ofst_pkg::*;

   localparam int SLOTS       = 64;
   localparam int DEPTH       = 8;
   localparam int HOT_COUNT   = 12;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEQ_W-1:0]    settled;
      logic                moved;
   } settle_word_type;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_kind         = KIND_ADD;
   logic [SLOT_W-1:0]   req_slot         = '0;
   logic [SEQ_W-1:0]    req_offer_seq    = '0;
   logic [CNT_W-1:0]    req_packet_count = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SEQ_W-1:0]    rsp_settled_value;
   logic                rsp_settled_moved;

   in_order_offer_settle_tracker #(
      .SLOT_COUNT   (SLOTS),
      .WINDOW_DEPTH (DEPTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_slot          (req_slot),
      .req_offer_seq     (req_offer_seq),
      .req_packet_count  (req_packet_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_settled_value (rsp_settled_value),
      .rsp_settled_moved (rsp_settled_moved)
   );

   // predicted window tables, one row of DEPTH entries per slot
   logic              win_used [SLOTS][DEPTH];
   logic [SEQ_W-1:0]  win_seq  [SLOTS][DEPTH];
   logic [CNT_W-1:0]  win_left [SLOTS][DEPTH];
   logic [SEQ_W-1:0]  settled_point [SLOTS];

   settle_word_type   pending_settles[$];
   logic [SLOT_W-1:0] hot_slots [HOT_COUNT];
   int                fail_count  = 0;
   int                cycle_count = 0;
   bit                bursty      = 1'b0;
   int                burst_left  = 0;

   rx_mode_type       rx_mode     = RX_ALWAYS;
   int                hold_len    = 0;
   int                hold_ticket = 0;
   int                hold_seen   = 0;
   int                hold_left   = 0;
   int                rx_tick     = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("in_order_offer_settle_tracker verification failed");
         $finish;
      end
   end

   // receiver: stall pattern per mode, plus a long hold-off when a ticket arrives
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_ready <= 1'b1;
            RX_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_ready <= ((rx_tick % 11) < 6);
            default:    rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      settle_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_settles.size() == 0) begin
            $error("response word with nothing expected: status %0d settled %0d moved %0d",
                   rsp_status, rsp_settled_value, rsp_settled_moved);
            fail_count++;
         end else begin
            want = pending_settles.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_settled_value !== want.settled) begin
               $error("settled_value: expected %0d, got %0d", want.settled,
                      rsp_settled_value);
               fail_count++;
            end
            if (rsp_settled_moved !== want.moved) begin
               $error("settled_moved: expected %0d, got %0d", want.moved,
                      rsp_settled_moved);
               fail_count++;
            end
         end
      end
   end

   function automatic void clear_windows();
      for (int s = 0; s < SLOTS; s++) begin
         settled_point[s] = '0;
         for (int e = 0; e < DEPTH; e++) begin
            win_used[s][e] = 1'b0;
            win_seq[s][e]  = '0;
            win_left[s][e] = '0;
         end
      end
   endfunction

   // lowest used entry of the row holding seq, -1 if none
   function automatic int lowest_match(input logic [SLOT_W-1:0] slot,
                                       input logic [SEQ_W-1:0] seq);
      for (int e = 0; e < DEPTH; e++)
         if (win_used[slot][e] && win_seq[slot][e] == seq)
            return e;
      return -1;
   endfunction

   function automatic settle_word_type predict_settle(input logic kind,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [SEQ_W-1:0] seq,
                                                      input logic [CNT_W-1:0] count);
      settle_word_type r;
      int hit;
      logic [SEQ_W-1:0] start;
      r.status  = STATUS_OK;
      r.settled = settled_point[slot];
      r.moved   = 1'b0;
      if (kind == KIND_ADD) begin
         r.status = STATUS_FULL;
         for (int e = 0; e < DEPTH; e++) begin
            if (!win_used[slot][e]) begin
               win_used[slot][e] = 1'b1;
               win_seq[slot][e]  = seq;
               win_left[slot][e] = count;
               r.status = STATUS_OK;
               break;
            end
         end
      end else begin
         start = settled_point[slot];
         hit = lowest_match(slot, seq);
         if (hit < 0)
            r.status = STATUS_UNKNOWN;
         else if (win_left[slot][hit] != 0)
            win_left[slot][hit] = win_left[slot][hit] - 1'b1;
         // retire in order while the next entry is present and drained
         for (int step = 0; step < DEPTH; step++) begin
            hit = lowest_match(slot, r.settled + 1'b1);
            if (hit < 0 || win_left[slot][hit] != 0)
               break;
            win_used[slot][hit] = 1'b0;
            r.settled = r.settled + 1'b1;
         end
         settled_point[slot] = r.settled;
         r.moved = (r.settled != start);
      end
      return r;
   endfunction

   // lowest sequence past the settled point that has no entry yet
   function automatic logic [SEQ_W-1:0] next_missing(input logic [SLOT_W-1:0] slot);
      logic [SEQ_W-1:0] seq;
      seq = settled_point[slot] + 1'b1;
      for (int k = 0; k < DEPTH; k++) begin
         if (lowest_match(slot, seq) < 0)
            return seq;
         seq = seq + 1'b1;
      end
      return seq;
   endfunction

   task automatic send_word(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [SEQ_W-1:0] seq, input logic [CNT_W-1:0] count);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_slot         <= slot;
      req_offer_seq    <= seq;
      req_packet_count <= count;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_settles.push_back(predict_settle(kind, slot, seq, count));
      if (bursty) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            burst_left = $urandom_range(1, 10);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_settles.size() != 0)
         @(posedge clock);
   endtask

   task automatic pick_hot_slots();
      for (int i = 0; i < HOT_COUNT; i++)
         hot_slots[i] = SLOT_W'($urandom_range(0, SLOTS - 1));
   endtask

   // mostly in-order add / dispose traffic on a few busy slots, some noise
   task automatic random_offer_words(input int n);
      logic [SLOT_W-1:0] slot;
      logic [SEQ_W-1:0]  seq;
      logic [CNT_W-1:0]  count;
      logic              kind;
      int                roll;
      int                draining[$];
      int                held[$];
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 80)
            slot = hot_slots[$urandom_range(0, HOT_COUNT - 1)];
         else
            slot = SLOT_W'($urandom_range(0, SLOTS - 1));
         draining.delete();
         held.delete();
         for (int e = 0; e < DEPTH; e++) begin
            if (win_used[slot][e]) held.push_back(e);
            if (win_used[slot][e] && win_left[slot][e] != 0) draining.push_back(e);
         end
         roll = $urandom_range(0, 99);
         if (held.size() == DEPTH)
            kind = (roll < 85) ? KIND_DISPOSE : KIND_ADD;
         else if (draining.size() == 0)
            kind = (roll < 80) ? KIND_ADD : KIND_DISPOSE;
         else
            kind = (roll < 45) ? KIND_ADD : KIND_DISPOSE;
         roll = $urandom_range(0, 99);
         if (kind == KIND_ADD) begin
            count = CNT_W'($urandom_range(1, 3));
            if (roll < 5) begin
               seq   = $urandom;
               count = CNT_W'($urandom_range(0, 65535));
            end else if (roll < 9 && held.size() != 0) begin
               seq   = win_seq[slot][held[$urandom_range(0, held.size() - 1)]];
               count = CNT_W'($urandom_range(0, 2));
            end else if (roll < 15) begin
               seq   = settled_point[slot] + SEQ_W'($urandom_range(1, 12));
               count = CNT_W'($urandom_range(0, 3));
            end else begin
               seq = next_missing(slot);
               roll = $urandom_range(0, 99);
               if (roll < 15)
                  count = '0;
               else if (roll >= 90)
                  count = CNT_W'($urandom_range(4, 12));
            end
         end else begin
            count = CNT_W'($urandom_range(0, 65535));
            if (roll < 80 && draining.size() != 0)
               seq = win_seq[slot][draining[$urandom_range(0, draining.size() - 1)]];
            else if (roll < 88)
               seq = settled_point[slot] + 1'b1;
            else if (roll < 94 && held.size() != 0)
               seq = win_seq[slot][held[$urandom_range(0, held.size() - 1)]];
            else
               seq = $urandom;
         end
         send_word(kind, slot, seq, count);
      end
   endtask

   task automatic test_directed_cases();
      bursty  = 1'b0;
      rx_mode <= RX_ALWAYS;
      // zero-count offer, then dispose at zero settles it
      send_word(KIND_ADD,     6'd0, 32'd1, 16'd0);
      send_word(KIND_DISPOSE, 6'd0, 32'd1, 16'hffff);
      // extreme fields, count only drops by one
      send_word(KIND_ADD,     6'd63, 32'hffff_ffff, 16'hffff);
      send_word(KIND_DISPOSE, 6'd63, 32'hffff_ffff, 16'd0);
      // duplicate sequence takes a second entry, dispose hits the lower one
      send_word(KIND_ADD,     6'd1, 32'd1, 16'd1);
      send_word(KIND_ADD,     6'd1, 32'd1, 16'd0);
      send_word(KIND_DISPOSE, 6'd1, 32'd1, 16'd0);
      // unknown offer still settles what is ready
      send_word(KIND_ADD,     6'd2, 32'd1, 16'd0);
      send_word(KIND_DISPOSE, 6'd2, 32'd7, 16'd0);
      // out-of-order adds, one dispose retires three
      send_word(KIND_ADD,     6'd3, 32'd3, 16'd0);
      send_word(KIND_ADD,     6'd3, 32'd2, 16'd0);
      send_word(KIND_ADD,     6'd3, 32'd1, 16'd1);
      send_word(KIND_DISPOSE, 6'd3, 32'd1, 16'd0);
      // fill the whole window, overflow it, then retire all of it at once
      send_word(KIND_ADD, 6'd4, 32'd1, 16'd1);
      for (int s = 2; s <= DEPTH; s++)
         send_word(KIND_ADD, 6'd4, SEQ_W'(s), 16'd0);
      send_word(KIND_ADD,     6'd4, 32'd9, 16'd0);
      send_word(KIND_DISPOSE, 6'd4, 32'd1, 16'd0);
      wait_quiet();
   endtask

   task automatic test_random_steady();
      bursty  = 1'b0;
      rx_mode <= RX_ALWAYS;
      pick_hot_slots();
      random_offer_words(330);
      wait_quiet();
   endtask

   task automatic test_random_bursty();
      bursty  = 1'b1;
      rx_mode <= RX_RANDOM;
      pick_hot_slots();
      random_offer_words(330);
      wait_quiet();
   endtask

   task automatic test_random_patterned();
      bursty  = 1'b1;
      rx_mode <= RX_PATTERN;
      pick_hot_slots();
      random_offer_words(230);
      rx_mode <= RX_SLOW;
      random_offer_words(100);
      wait_quiet();
   endtask

   // response side held off long enough for the block to back up its input
   task automatic test_output_hold_off();
      bursty      = 1'b0;
      rx_mode     <= RX_ALWAYS;
      hold_len    <= 400;
      hold_ticket <= hold_ticket + 1;
      pick_hot_slots();
      random_offer_words(40);
      wait_quiet();
   endtask

   task automatic test_drain_pause();
      bursty  = 1'b1;
      rx_mode <= RX_RANDOM;
      pick_hot_slots();
      random_offer_words(40);
      wait_quiet();
      random_offer_words(40);
      wait_quiet();
   endtask

   initial begin
      clear_windows();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_steady();
      test_random_bursty();
      test_random_patterned();
      test_output_hold_off();
      test_drain_pause();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("in_order_offer_settle_tracker verification clean");
      else
         $display("in_order_offer_settle_tracker verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ofst_pkg.sv
sv/ofst_ram.sv
sv/ofst_row.sv
sv/in_order_offer_settle_tracker.sv
bench/tb.sv
